[rtl/core/gsx_pkg.sv]
package gsx_pkg;

   // Operand and result widths
   localparam int POS_W   = 28;             // signed Q4.24 positions
   localparam int TOL_W   = 27;             // unsigned Q3.24 stop width
   localparam int PASS_W  = 7;              // reported pass count
   localparam int FRAC_BITS = 24;
   localparam int D_W     = POS_W + 1;      // interval width, signed
   localparam int MUL_W   = 32;             // shared multiplier operand width
   localparam int PROD_W  = 2 * MUL_W;
   localparam int RND_W   = PROD_W - FRAC_BITS;
   localparam int Y_W     = RND_W + 1;      // cubic value, signed

   localparam int MAX_ITER_DEF = 64;
   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(16777);

   // Golden factor round(2^FRAC_BITS / 1.618)
   localparam logic [MUL_W-1:0] GOLD_K =
      MUL_W'(((64'd1 << FRAC_BITS) * 64'd1000 + 64'd809) / 64'd1618);
   localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(64'd1 << (FRAC_BITS - 1));

   // Datapath operations
   localparam logic [3:0] OP_NOP    = 4'd0;
   localparam logic [3:0] OP_LOAD   = 4'd1;
   localparam logic [3:0] OP_DIFF   = 4'd2;
   localparam logic [3:0] OP_MUL_GD = 4'd3;
   localparam logic [3:0] OP_PROBE  = 4'd4;
   localparam logic [3:0] OP_MUL_SQ = 4'd5;
   localparam logic [3:0] OP_SQ     = 4'd6;
   localparam logic [3:0] OP_MUL_CU = 4'd7;
   localparam logic [3:0] OP_EVAL_Y = 4'd8;
   localparam logic [3:0] OP_TEST   = 4'd9;
   localparam logic [3:0] OP_FINISH = 4'd10;

   // Probe selection
   localparam logic [1:0] PRB_X1  = 2'd0;
   localparam logic [1:0] PRB_X2  = 2'd1;
   localparam logic [1:0] PRB_NEW = 2'd2;   // the probe rebuilt by the last pass

   // Sequencer conditions
   localparam logic [2:0] CND_NEXT     = 3'd0;
   localparam logic [2:0] CND_JUMP     = 3'd1;
   localparam logic [2:0] CND_EXIT     = 3'd2;
   localparam logic [2:0] CND_START    = 3'd3;
   localparam logic [2:0] CND_OUT_FREE = 3'd4;

   localparam int PC_W = 5;
   localparam logic [PC_W-1:0] STEP_IDLE   = PC_W'(0);
   localparam logic [PC_W-1:0] STEP_TEST   = PC_W'(13);
   localparam logic [PC_W-1:0] STEP_FINISH = PC_W'(21);
   localparam logic [PC_W-1:0] LAST_STEP   = STEP_FINISH;

   typedef struct packed {
      logic [3:0]      op;
      logic [1:0]      prb;
      logic [2:0]      cnd;
      logic [PC_W-1:0] target;
   } ucw_type;

   function automatic ucw_type cw(input logic [3:0] op, input logic [1:0] prb,
                                  input logic [2:0] cnd, input logic [PC_W-1:0] target);
      ucw_type w;
      w.op     = op;
      w.prb    = prb;
      w.cnd    = cnd;
      w.target = target;
      return w;
   endfunction

   // Microcode program
   function automatic ucw_type ucode_rom(input logic [PC_W-1:0] addr);
      ucw_type w;
      case (addr)
         5'd0:    w = cw(OP_LOAD,   PRB_X1,  CND_START,    STEP_IDLE);
         5'd1:    w = cw(OP_DIFF,   PRB_X1,  CND_NEXT,     STEP_IDLE);
         5'd2:    w = cw(OP_MUL_GD, PRB_X1,  CND_NEXT,     STEP_IDLE);
         5'd3:    w = cw(OP_PROBE,  PRB_X1,  CND_NEXT,     STEP_IDLE);
         5'd4:    w = cw(OP_PROBE,  PRB_X2,  CND_NEXT,     STEP_IDLE);
         5'd5:    w = cw(OP_MUL_SQ, PRB_X1,  CND_NEXT,     STEP_IDLE);
         5'd6:    w = cw(OP_SQ,     PRB_X1,  CND_NEXT,     STEP_IDLE);
         5'd7:    w = cw(OP_MUL_CU, PRB_X1,  CND_NEXT,     STEP_IDLE);
         5'd8:    w = cw(OP_EVAL_Y, PRB_X1,  CND_NEXT,     STEP_IDLE);
         5'd9:    w = cw(OP_MUL_SQ, PRB_X2,  CND_NEXT,     STEP_IDLE);
         5'd10:   w = cw(OP_SQ,     PRB_X2,  CND_NEXT,     STEP_IDLE);
         5'd11:   w = cw(OP_MUL_CU, PRB_X2,  CND_NEXT,     STEP_IDLE);
         5'd12:   w = cw(OP_EVAL_Y, PRB_X2,  CND_NEXT,     STEP_IDLE);
         5'd13:   w = cw(OP_TEST,   PRB_X1,  CND_EXIT,     STEP_FINISH);
         5'd14:   w = cw(OP_DIFF,   PRB_X1,  CND_NEXT,     STEP_IDLE);
         5'd15:   w = cw(OP_MUL_GD, PRB_X1,  CND_NEXT,     STEP_IDLE);
         5'd16:   w = cw(OP_PROBE,  PRB_NEW, CND_NEXT,     STEP_IDLE);
         5'd17:   w = cw(OP_MUL_SQ, PRB_NEW, CND_NEXT,     STEP_IDLE);
         5'd18:   w = cw(OP_SQ,     PRB_NEW, CND_NEXT,     STEP_IDLE);
         5'd19:   w = cw(OP_MUL_CU, PRB_NEW, CND_NEXT,     STEP_IDLE);
         5'd20:   w = cw(OP_EVAL_Y, PRB_NEW, CND_JUMP,     STEP_TEST);
         5'd21:   w = cw(OP_FINISH, PRB_X1,  CND_OUT_FREE, STEP_IDLE);
         default: w = cw(OP_NOP,    PRB_X1,  CND_JUMP,     STEP_IDLE);
      endcase
      return w;
   endfunction

endpackage

[rtl/core/golden_section_extremum_search.sv]
// A new request transaction is taken only in the idle step, once the previous result has
// been written to the result register; a search makes at most MAX_ITER passes.
// Every pass runs 8 microcode steps; three of them share the single 32x32 multiplier
// (width times golden factor, square, cube) and the rest load, round and compare.
// Reset (synchronous, active high) returns the sequencer to its idle step, clears the
// result valid and loads the tolerance register with 16777 (about 0.001).
module golden_section_extremum_search #(
   parameter int MAX_ITER = gsx_pkg::MAX_ITER_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_type,
   input  logic signed [gsx_pkg::POS_W-1:0]   req_end_a,
   input  logic signed [gsx_pkg::POS_W-1:0]   req_end_b,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [gsx_pkg::POS_W-1:0]   rsp_location,
   output logic        [gsx_pkg::PASS_W-1:0]  rsp_passes,
   output logic                               rsp_hit_limit,
   // tolerance register write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic        [gsx_pkg::TOL_W-1:0]   csr_tolerance
);
   import gsx_pkg::*;

   localparam int CNT_W = $clog2(MAX_ITER + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITER);

   // Sequencer
   logic [PC_W-1:0] pc_ff, pc_in;
   ucw_type         ucw;

   // Search state: interval ends, probes and their cubic values
   logic signed [POS_W-1:0] a_ff, a_in, b_ff, b_in;
   logic signed [POS_W-1:0] x1_ff, x1_in, x2_ff, x2_in;
   logic signed [Y_W-1:0]   y1_ff, y1_in, y2_ff, y2_in;
   logic [D_W-1:0]          dmag_ff, dmag_in;
   logic                    dneg_ff, dneg_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic                    pneg_ff, pneg_in;
   logic [MUL_W-1:0]        sq_ff, sq_in;
   logic [CNT_W-1:0]        passes_ff, passes_in;
   logic                    limit_ff, limit_in;
   logic                    want_max_ff, want_max_in;
   logic                    drop_a_ff, drop_a_in;
   logic [TOL_W-1:0]        tol_ff, tol_in;

   // Result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [POS_W-1:0] rsp_location_ff, rsp_location_in;
   logic [PASS_W-1:0]       rsp_passes_ff, rsp_passes_in;
   logic                    rsp_hit_limit_ff, rsp_hit_limit_in;

   // Datapath nets
   logic                    req_accept, out_free;
   logic                    use_x2;
   logic signed [POS_W-1:0] probe;
   logic [POS_W-1:0]        probe_mag;
   logic signed [D_W-1:0]   a_ext, b_ext, diff_ba, diff_ab, mid_sum, rnd_ext;
   logic [MUL_W-1:0]        mul_a, mul_b;
   logic [PROD_W-1:0]       mul_p, rnd_sum;
   logic [RND_W-1:0]        rnd_mag;
   logic signed [Y_W-1:0]   rnd_y, four_p;
   logic                    below_tol, at_limit, exit_now, drop_a;
   logic [CNT_W+PASS_W-1:0] passes_wide;

   assign ucw        = ucode_rom(pc_ff);
   assign req_stall  = (pc_ff != STEP_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;

   // Pick the probe a step works on; the rebuilt one follows the last drop
   always_comb begin
      case (ucw.prb)
         PRB_X1:  use_x2 = 1'b0;
         PRB_X2:  use_x2 = 1'b1;
         PRB_NEW: use_x2 = drop_a_ff;
         default: use_x2 = 1'b0;
      endcase
   end

   assign probe     = use_x2 ? x2_ff : x1_ff;
   assign probe_mag = probe[POS_W-1] ? POS_W'(-probe) : POS_W'(probe);

   // Interval width, both signs side by side so only one subtract sits in the path
   assign a_ext   = D_W'(a_ff);
   assign b_ext   = D_W'(b_ff);
   assign diff_ba = b_ext - a_ext;
   assign diff_ab = a_ext - b_ext;
   assign mid_sum = a_ext + b_ext;

   // Shared multiplier on magnitudes; sign travels beside the product
   always_comb begin
      case (ucw.op)
         OP_MUL_GD: begin
            mul_a = MUL_W'(dmag_ff);
            mul_b = GOLD_K;
         end
         OP_MUL_SQ: begin
            mul_a = MUL_W'(probe_mag);
            mul_b = MUL_W'(probe_mag);
         end
         OP_MUL_CU: begin
            mul_a = sq_ff;
            mul_b = MUL_W'(probe_mag);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   // Round half up on the magnitude, then shift out the fraction
   assign rnd_sum = prod_ff + RND_HALF;
   assign rnd_mag = rnd_sum[PROD_W-1:FRAC_BITS];
   assign rnd_ext = $signed(rnd_mag[D_W-1:0]);
   assign rnd_y   = $signed({1'b0, rnd_mag});
   assign four_p  = $signed(Y_W'({probe_mag, 2'b00}));

   // Stop tests and the drop decision (ties drop the a side)
   assign below_tol = dmag_ff < D_W'(tol_ff);
   assign at_limit  = passes_ff >= CNT_MAX;
   assign exit_now  = below_tol || at_limit;
   assign drop_a    = want_max_ff ? (y1_ff <= y2_ff) : (y1_ff >= y2_ff);

   assign passes_wide = {{PASS_W{1'b0}}, passes_ff};

   // Next step
   always_comb begin
      case (ucw.cnd)
         CND_NEXT:     pc_in = pc_ff + PC_W'(1);
         CND_JUMP:     pc_in = ucw.target;
         CND_EXIT:     pc_in = exit_now ? ucw.target : pc_ff + PC_W'(1);
         CND_START:    pc_in = req_accept ? pc_ff + PC_W'(1) : pc_ff;
         CND_OUT_FREE: pc_in = out_free ? ucw.target : pc_ff;
         default:      pc_in = STEP_IDLE;
      endcase
   end

   // Datapath
   always_comb begin
      a_in             = a_ff;
      b_in             = b_ff;
      x1_in            = x1_ff;
      x2_in            = x2_ff;
      y1_in            = y1_ff;
      y2_in            = y2_ff;
      dmag_in          = dmag_ff;
      dneg_in          = dneg_ff;
      prod_in          = prod_ff;
      pneg_in          = pneg_ff;
      sq_in            = sq_ff;
      passes_in        = passes_ff;
      limit_in         = limit_ff;
      want_max_in      = want_max_ff;
      drop_a_in        = drop_a_ff;
      rsp_location_in  = rsp_location_ff;
      rsp_passes_in    = rsp_passes_ff;
      rsp_hit_limit_in = rsp_hit_limit_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      tol_in           = (csr_valid && csr_ready) ? csr_tolerance : tol_ff;

      case (ucw.op)
         OP_LOAD: begin
            if (req_accept) begin
               want_max_in = req_type;
               a_in        = req_end_a;
               b_in        = req_end_b;
               passes_in   = '0;
               limit_in    = 1'b0;
               drop_a_in   = 1'b0;
            end
         end
         OP_DIFF: begin
            dneg_in = diff_ba[D_W-1];
            dmag_in = diff_ba[D_W-1] ? diff_ab : diff_ba;
         end
         OP_MUL_GD: begin
            prod_in = mul_p;
            pneg_in = dneg_ff;
         end
         OP_PROBE: begin
            // x1 = b - gold(b-a), x2 = a + gold(b-a)
            if (use_x2) begin
               x2_in = POS_W'(pneg_ff ? a_ext - rnd_ext : a_ext + rnd_ext);
            end else begin
               x1_in = POS_W'(pneg_ff ? b_ext + rnd_ext : b_ext - rnd_ext);
            end
         end
         OP_MUL_SQ: begin
            prod_in = mul_p;
            pneg_in = 1'b0;
         end
         OP_SQ: begin
            sq_in = rnd_mag[MUL_W-1:0];
         end
         OP_MUL_CU: begin
            prod_in = mul_p;
            pneg_in = probe[POS_W-1];
         end
         OP_EVAL_Y: begin
            // x^3 - 4x = sign(x) * (|x|^3 - 4|x|): one subtract with swapped operands
            if (use_x2) begin
               y2_in = pneg_ff ? four_p - rnd_y : rnd_y - four_p;
            end else begin
               y1_in = pneg_ff ? four_p - rnd_y : rnd_y - four_p;
            end
         end
         OP_TEST: begin
            if (exit_now) begin
               limit_in = !below_tol && at_limit;
            end else begin
               // Narrow: the kept probe moves over and keeps its cubic value
               passes_in = passes_ff + CNT_W'(1);
               drop_a_in = drop_a;
               if (drop_a) begin
                  a_in  = x1_ff;
                  x1_in = x2_ff;
                  y1_in = y2_ff;
               end else begin
                  b_in  = x2_ff;
                  x2_in = x1_ff;
                  y2_in = y1_ff;
               end
            end
         end
         OP_FINISH: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_location_in  = mid_sum[POS_W:1];  // floor of the midpoint
               rsp_passes_in    = passes_wide[PASS_W-1:0];
               rsp_hit_limit_in = limit_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
         tol_ff       <= TOL_RESET;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         tol_ff       <= tol_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      a_ff             <= a_in;
      b_ff             <= b_in;
      x1_ff            <= x1_in;
      x2_ff            <= x2_in;
      y1_ff            <= y1_in;
      y2_ff            <= y2_in;
      dmag_ff          <= dmag_in;
      dneg_ff          <= dneg_in;
      prod_ff          <= prod_in;
      pneg_ff          <= pneg_in;
      sq_ff            <= sq_in;
      passes_ff        <= passes_in;
      limit_ff         <= limit_in;
      want_max_ff      <= want_max_in;
      drop_a_ff        <= drop_a_in;
      rsp_location_ff  <= rsp_location_in;
      rsp_passes_ff    <= rsp_passes_in;
      rsp_hit_limit_ff <= rsp_hit_limit_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_location  = rsp_location_ff;
   assign rsp_passes    = rsp_passes_ff;
   assign rsp_hit_limit = rsp_hit_limit_ff;

   // Sequencer never leaves the program
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= LAST_STEP)
      else $error("sequencer step out of program");

   // Pass counter never runs past the limit while searching
   a_pass_bound: assert property (@(posedge clock) disable iff (reset)
      (pc_ff != STEP_IDLE) |-> (passes_ff <= CNT_MAX))
      else $error("pass counter beyond limit");

   // Limit flag only when the full pass budget was spent
   a_limit_count: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == STEP_FINISH && limit_ff) |-> (passes_ff == CNT_MAX))
      else $error("limit flag without full pass count");

   // A waiting result is never overwritten by the finish step
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == STEP_FINISH && rsp_valid_ff && rsp_stall) |=> $stable(rsp_location_ff))
      else $error("pending result overwritten");

endmodule
